// ===== rtl/mexp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared constants for the modular exponentiation block.
// ----------------------------------------------------------------------------
package mexp_pkg;

  // width of every field on the ports
  localparam int unsigned DATA_W = 32;

endpackage
`default_nettype wire

// ===== rtl/mexp_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mexp_in_if
// Input channel: base and exponent with valid/ready handshake.
// ----------------------------------------------------------------------------
interface mexp_in_if;
  import mexp_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] base;
  logic [DATA_W-1:0] exponent;

  modport source (output valid, output base, output exponent, input ready);
  modport sink   (input valid, input base, input exponent, output ready);

endinterface
`default_nettype wire

// ===== rtl/mexp_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mexp_out_if
// Result channel: residue with valid/ready handshake.
// ----------------------------------------------------------------------------
interface mexp_out_if;
  import mexp_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] residue;

  modport source (output valid, output residue, input ready);
  modport sink   (input valid, input residue, output ready);

endinterface
`default_nettype wire

// ===== rtl/mexp_mulred.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mexp_mulred
// Bit-serial interleaved multiply-and-reduce: r = a * b mod n, one bit of b
// per cycle, MSB first. Needs r < n and a <= n; n of zero wraps at 2^WIDTH.
// ----------------------------------------------------------------------------
module mexp_mulred #(
  parameter int unsigned WIDTH = 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [WIDTH-1:0] a,
  input  wire logic [WIDTH-1:0] b,
  input  wire logic [WIDTH-1:0] n,
  output logic                  done,
  output logic [WIDTH-1:0]      res
);

  localparam int unsigned CNT_W = $clog2(WIDTH + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [WIDTH-1:0] b_r, b_nxt;
  logic [WIDTH-1:0] r_r, r_nxt;

  logic [WIDTH+1:0] sum;
  logic [WIDTH+2:0] d1;
  logic [WIDTH+2:0] d2;
  logic [WIDTH-1:0] r_step;

  always_comb begin
    sum = {1'b0, r_r, 1'b0} + {2'b00, (b_r[WIDTH-1] ? a : {WIDTH{1'b0}})};
    d1  = {1'b0, sum} - {3'b000, n};
    d2  = {1'b0, sum} - {2'b00, n, 1'b0};
    // sum < 3n, so at most two subtractions of n
    priority if (n == '0) begin
      r_step = sum[WIDTH-1:0];
    end else if (!d2[WIDTH+2]) begin
      r_step = d2[WIDTH-1:0];
    end else if (!d1[WIDTH+2]) begin
      r_step = d1[WIDTH-1:0];
    end else begin
      r_step = sum[WIDTH-1:0];
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    b_nxt    = b_r;
    r_nxt    = r_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(WIDTH);
      b_nxt    = b;
      r_nxt    = '0;
    end else if (busy_r) begin
      r_nxt   = r_step;
      b_nxt   = {b_r[WIDTH-2:0], 1'b0};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    b_r <= b_nxt;
    r_r <= r_nxt;
  end

  assign done = done_r;
  assign res  = r_r;

endmodule
`default_nettype wire

// ===== rtl/modular_exponentiation_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Work per item: one pass of the multiply-reduce unit to reduce the base, one
// multiply per set exponent bit and one squaring per exponent bit below the
// highest set bit; a zero exponent skips the unit and goes straight to output.
// One item at a time; the next item can be taken in the cycle after the result
// loads into the output register.
// Reset (synchronous, rst_n low) idles the block and sets the modulus to 1.
// ----------------------------------------------------------------------------
// modular_exponentiation_top
// Right-to-left square-and-multiply over a shared multiply-reduce unit.
// ----------------------------------------------------------------------------
module modular_exponentiation_top #(
  parameter int unsigned WIDTH = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_wr_en,
  input  wire logic [mexp_pkg::DATA_W-1:0]    cfg_wr_data,
  mexp_in_if.sink                             in_chan,
  mexp_out_if.source                          out_chan
);
  import mexp_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RED  = 5'b00010,
    S_MUL  = 5'b00100,
    S_SQR  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [WIDTH-1:0]  mod_r, mod_nxt;
  logic [WIDTH-1:0]  x_r, x_nxt;
  logic [WIDTH-1:0]  acc_r, acc_nxt;
  logic [WIDTH-1:0]  e_r, e_nxt;
  logic              start_r, start_nxt;
  logic              oval_r, oval_nxt;
  logic [DATA_W-1:0] odata_r, odata_nxt;

  logic              mr_done;
  logic [WIDTH-1:0]  mr_res;
  logic [WIDTH-1:0]  mr_a;
  logic [WIDTH-1:0]  mr_b;
  logic              in_acc;

  assign in_acc = in_chan.valid && (state_r == S_IDLE);

  // reduction of the base is x * 1; otherwise x is the multiplicand
  always_comb begin
    mr_a = (state_r == S_RED) ? {{(WIDTH-1){1'b0}}, 1'b1} : x_r;
    mr_b = (state_r == S_MUL) ? acc_r : x_r;
  end

  mexp_mulred #(
    .WIDTH (WIDTH)
  ) u_mulred (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_r),
    .a     (mr_a),
    .b     (mr_b),
    .n     (mod_r),
    .done  (mr_done),
    .res   (mr_res)
  );

  always_comb begin
    state_nxt = state_r;
    mod_nxt   = mod_r;
    x_nxt     = x_r;
    acc_nxt   = acc_r;
    e_nxt     = e_r;
    start_nxt = 1'b0;
    oval_nxt  = oval_r;
    odata_nxt = odata_r;

    if (oval_r && out_chan.ready) begin
      oval_nxt = 1'b0;
    end
    if (cfg_wr_en) begin
      mod_nxt = cfg_wr_data[WIDTH-1:0];
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          x_nxt   = in_chan.base[WIDTH-1:0];
          e_nxt   = in_chan.exponent[WIDTH-1:0];
          acc_nxt = {{(WIDTH-1){1'b0}}, 1'b1};
          if (in_chan.exponent[WIDTH-1:0] == '0) begin
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_RED;
            start_nxt = 1'b1;
          end
        end
      end
      S_RED: begin
        if (mr_done) begin
          x_nxt     = mr_res;
          state_nxt = e_r[0] ? S_MUL : S_SQR;
          start_nxt = 1'b1;
        end
      end
      S_MUL: begin
        if (mr_done) begin
          acc_nxt = mr_res;
          // no higher exponent bits left: further squares are unused
          if (e_r[WIDTH-1:1] == '0) begin
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_SQR;
            start_nxt = 1'b1;
          end
        end
      end
      S_SQR: begin
        if (mr_done) begin
          x_nxt     = mr_res;
          e_nxt     = {1'b0, e_r[WIDTH-1:1]};
          state_nxt = e_r[1] ? S_MUL : S_SQR;
          start_nxt = 1'b1;
        end
      end
      S_OUT: begin
        if (!oval_r || out_chan.ready) begin
          odata_nxt = DATA_W'(acc_r);
          oval_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mod_r   <= {{(WIDTH-1){1'b0}}, 1'b1};
      start_r <= 1'b0;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mod_r   <= mod_nxt;
      start_r <= start_nxt;
      oval_r  <= oval_nxt;
    end
    x_r     <= x_nxt;
    acc_r   <= acc_nxt;
    e_r     <= e_nxt;
    odata_r <= odata_nxt;
  end

  assign in_chan.ready    = (state_r == S_IDLE);
  assign out_chan.valid   = oval_r;
  assign out_chan.residue = odata_r;

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the modular exponentiation block. A table of directed items runs
// first; random items follow, under several moduli. Each residue is compared
// with an in-bench square-and-multiply predictor, or with the table value for
// typed rows. Both channel sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  import mexp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned LONG_HOLD   = 3000;
  localparam int unsigned SETTLE      = 40;
  localparam int unsigned N_PHASES    = 6;
  localparam int unsigned PHASE_ITEMS = 42;

  typedef struct packed {
    bit                set_mod;
    logic [DATA_W-1:0] modulus;
    logic [DATA_W-1:0] base;
    logic [DATA_W-1:0] exponent;
    bit                typed;
    logic [DATA_W-1:0] residue;
  } dir_row_t;

  localparam int unsigned N_DIR = 20;

  // rows with typed = 0 are checked against the predictor
  localparam dir_row_t DIR_ROWS [0:N_DIR-1] = '{
    // modulus 1 from reset
    '{1'b0, 32'd0,          32'd0,          32'd0,          1'b1, 32'd1},
    '{1'b0, 32'd0,          32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1, 32'd0},
    '{1'b0, 32'd0,          32'd5,          32'd1,          1'b1, 32'd0},
    // modulus 0: products wrap
    '{1'b1, 32'd0,          32'd3,          32'd2,          1'b1, 32'd9},
    '{1'b0, 32'd0,          32'hFFFF_FFFF,  32'd2,          1'b1, 32'd1},
    '{1'b0, 32'd0,          32'd2,          32'd32,         1'b1, 32'd0},
    '{1'b0, 32'd0,          32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1, 32'hFFFF_FFFF},
    // largest modulus
    '{1'b1, 32'hFFFF_FFFF,  32'hFFFF_FFFF,  32'd5,          1'b1, 32'd0},
    '{1'b0, 32'hFFFF_FFFF,  32'd0,          32'd0,          1'b1, 32'd1},
    '{1'b0, 32'hFFFF_FFFF,  32'hFFFF_FFFE,  32'hFFFF_FFFF,  1'b0, 32'd0},
    '{1'b0, 32'hFFFF_FFFF,  32'h1234_5678,  32'd1,          1'b1, 32'h1234_5678},
    // prime modulus, bases below it, above it and at multiples of it
    '{1'b1, 32'd1000003,    32'd2,          32'd1000002,    1'b0, 32'd0},
    '{1'b0, 32'd1000003,    32'd2000006,    32'd3,          1'b1, 32'd0},
    '{1'b0, 32'd1000003,    32'd1000004,    32'd7,          1'b1, 32'd1},
    '{1'b0, 32'd1000003,    32'd0,          32'd0,          1'b1, 32'd1},
    '{1'b0, 32'd1000003,    32'd0,          32'd5,          1'b1, 32'd0},
    '{1'b1, 32'd2,          32'd3,          32'hFFFF_FFFF,  1'b1, 32'd1},
    '{1'b0, 32'd2,          32'd4,          32'd1,          1'b1, 32'd0},
    '{1'b1, 32'h8000_0000,  32'd3,          32'h8000_0000,  1'b0, 32'd0},
    '{1'b0, 32'h8000_0000,  32'h7FFF_FFFF,  32'hAAAA_AAAA,  1'b0, 32'd0}
  };

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [DATA_W-1:0] cfg_wr_data;

  mexp_in_if  in_chan ();
  mexp_out_if out_chan ();

  modular_exponentiation_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_chan    (in_chan),
    .out_chan   (out_chan)
  );

  logic [DATA_W-1:0] modulus_model;
  logic [DATA_W-1:0] residue_q[$];
  int unsigned       err_cnt;
  int unsigned       cycle_cnt;
  bit                src_quiet;
  bit                sink_quiet;
  bit                hold_req;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [63:0] mul_mod(input logic [63:0] a, input logic [63:0] b,
                                          input logic [DATA_W-1:0] n);
    logic [63:0] prod;
    prod = a * b;
    if (n == '0) return {32'd0, prod[31:0]};
    return prod % {32'd0, n};
  endfunction

  // right-to-left square-and-multiply
  function automatic logic [DATA_W-1:0] mod_pow(input logic [DATA_W-1:0] b,
                                                input logic [DATA_W-1:0] e,
                                                input logic [DATA_W-1:0] n);
    logic [63:0] acc;
    logic [63:0] sq;
    acc = 64'd1;
    sq  = {32'd0, b};
    if (n != '0) sq = sq % {32'd0, n};
    if (e != '0) begin
      for (int i = 0; i < DATA_W; i++) begin
        if (e[i]) acc = mul_mod(acc, sq, n);
        sq = mul_mod(sq, sq, n);
      end
      if (n != '0) acc = acc % {32'd0, n};
    end
    return acc[DATA_W-1:0];
  endfunction

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (residue_q.size() == 0) begin
        $error("unexpected item: residue actual %h", out_chan.residue);
        err_cnt++;
      end else begin
        if (out_chan.residue !== residue_q[0]) begin
          $error("residue mismatch: expected %h actual %h", residue_q[0], out_chan.residue);
          err_cnt++;
        end
        void'(residue_q.pop_front());
      end
    end
  end

  // result side: random stalls plus one long hold-off on request
  initial begin : result_sink
    int unsigned idle_left;
    int unsigned hold_left;
    idle_left = 0;
    hold_left = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_chan.valid && out_chan.ready)
        idle_left = sink_quiet ? 0 : $urandom_range(0, 4);
      if (hold_req) begin
        hold_left = LONG_HOLD;
        hold_req  = 1'b0;
      end
      @(negedge clk);
      if (hold_left > 0) begin
        out_chan.ready <= 1'b0;
        hold_left--;
      end else if (idle_left > 0) begin
        out_chan.ready <= 1'b0;
        idle_left--;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  task automatic send_item(input logic [DATA_W-1:0] b, input logic [DATA_W-1:0] e,
                           input bit typed, input logic [DATA_W-1:0] want);
    int unsigned gap;
    gap = src_quiet ? 0 : $urandom_range(0, 4);
    @(negedge clk);
    while (gap > 0) begin
      in_chan.valid    <= 1'b0;
      in_chan.base     <= $urandom;
      in_chan.exponent <= $urandom;
      gap--;
      @(negedge clk);
    end
    in_chan.valid    <= 1'b1;
    in_chan.base     <= b;
    in_chan.exponent <= e;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    residue_q.push_back(typed ? want : mod_pow(b, e, modulus_model));
  endtask

  // drop valid and wait until every residue is back
  task automatic drain;
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (residue_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_modulus(input logic [DATA_W-1:0] value);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    modulus_model = value;
  endtask

  function automatic logic [DATA_W-1:0] pick_modulus();
    case ($urandom_range(0, 6))
      0:       return '0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom_range(2, 255);
      3:       return 32'd65521;
      4:       return 32'hFFFF_FFFB;
      5:       return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_base();
    case ($urandom_range(0, 7))
      4:       return '0;
      5:       return modulus_model - 1;
      6:       return modulus_model + $urandom_range(0, 3);
      7:       return 32'd1;
      default: return $urandom;
    endcase
  endfunction

  // mostly short exponents to keep the run short; full width now and then
  function automatic logic [DATA_W-1:0] pick_exponent();
    int unsigned roll;
    int unsigned bits;
    roll = $urandom_range(0, 9);
    bits = $urandom_range(1, 10);
    if (roll < 7) return $urandom & ((32'd1 << bits) - 1);
    if (roll < 9) return $urandom;
    return $urandom_range(0, 1);
  endfunction

  initial begin : stimulus
    rst_n            = 1'b0;
    cfg_wr_en        = 1'b0;
    cfg_wr_data      = '0;
    in_chan.valid    = 1'b0;
    in_chan.base     = '0;
    in_chan.exponent = '0;
    modulus_model    = 32'd1;
    err_cnt          = 0;
    cycle_cnt        = 0;
    src_quiet        = 1'b0;
    sink_quiet       = 1'b0;
    hold_req         = 1'b0;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < N_DIR; r++) begin
      if (DIR_ROWS[r].set_mod) write_modulus(DIR_ROWS[r].modulus);
      send_item(DIR_ROWS[r].base, DIR_ROWS[r].exponent, DIR_ROWS[r].typed,
                DIR_ROWS[r].residue);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      write_modulus(pick_modulus());
      src_quiet  = (p == 2) || (p == 4);
      sink_quiet = (p == 4);
      // receiver holds off while the sender keeps offering items
      if (p == 2) hold_req = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 3 && k == PHASE_ITEMS / 2) drain();
        send_item(pick_base(), pick_exponent(), 1'b0, '0);
      end
    end

    drain();
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
